### hw/rtl/pur_pkg.sv
// Shared types and constants for the polyphase up/FIR/down resampler.
// Beat structs, register indexes, opcode encoding and fixed-point limits.
// No dependencies.
package pur_pkg;

  // Default sizing of the tap store, history line and factors.
  localparam int MAX_TAPS_DEF = 256;
  localparam int MAX_UP_DEF   = 16;
  localparam int MAX_DOWN_DEF = 64;

  // Configuration register widths and port widths.
  localparam int UP_REG_W   = 5;
  localparam int DOWN_REG_W = 7;
  localparam int TC_REG_W   = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_UP_FACTOR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOWN_FACTOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT   = 2'd2;

  // Fixed-point rounding from Q3.29 products back to Q1.15.
  localparam int                 FRAC_SHIFT = 14;
  localparam int                 RND_HALF   = 8192;
  localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_COEF   = 1'b1
  } op_e;

  typedef struct packed {
    op_e                opcode;
    logic signed [15:0] sample_in;
    logic [7:0]         tap_index;
    logic signed [15:0] tap_value;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] sample_out;
    logic               last_of_input;
  } out_beat_t;

endpackage

### hw/rtl/polyphase_upfirdn_resampler.sv
// Top level of the polyphase rational resampler: one shared MAC under a sequencer.
// Depends on pur_pkg for beat structs, register indexes and rounding constants.
//
// Channel | Direction | Handshake                    | Payload
// in      | input     | in_valid_i / in_ready_o      | in_i  (pur_pkg::in_beat_t)
// out     | output    | out_valid_o / out_ready_i    | out_o (pur_pkg::out_beat_t)
// cfg     | input     | cfg_valid_i / cfg_ready_o    | cfg_index_i, cfg_data_i
//
// A coefficient beat is taken in idle and a bypass sample goes straight to the output step.
// Any other sample first scans its U phases to mark the emitting ones, then steps past each
// skipped phase before the last emitting one (all U when none emits). Each emitted phase j
// has a setup step, ceil((tap_count - j) / U) taps at one tap per cycle on the shared MAC,
// a drain of the product pipeline and an output step. The input is ready only between
// samples; a waiting result stalls the sequencer only once the next one is done.
module polyphase_upfirdn_resampler #(
  parameter int MAX_TAPS = pur_pkg::MAX_TAPS_DEF,
  parameter int MAX_UP   = pur_pkg::MAX_UP_DEF,
  parameter int MAX_DOWN = pur_pkg::MAX_DOWN_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  pur_pkg::in_beat_t                in_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output pur_pkg::out_beat_t               out_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [pur_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [pur_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import pur_pkg::*;

  localparam int A_W   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int TC_W  = $clog2(MAX_TAPS + 1);
  localparam int T_W   = $clog2(MAX_TAPS + MAX_UP + 1);
  localparam int U_W   = $clog2(MAX_UP + 1);
  localparam int J_W   = (MAX_UP > 1) ? $clog2(MAX_UP) : 1;
  localparam int D_W   = $clog2(MAX_DOWN + 1);
  localparam int PH_W  = (MAX_DOWN > 1) ? $clog2(MAX_DOWN) : 1;
  localparam int ACC_W = 33 + A_W;
  localparam int RW    = ACC_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_NEXT,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } st_e;

  // Control state.
  st_e                state_q, state_d;
  logic [UP_REG_W-1:0]   up_q, up_d;
  logic [DOWN_REG_W-1:0] down_q, down_d;
  logic [TC_REG_W-1:0]   tc_q, tc_d;
  logic [J_W-1:0]     j_q, j_d;
  logic [J_W-1:0]     last_j_q, last_j_d;
  logic [MAX_UP-1:0]  emit_vec_q, emit_vec_d;
  logic [PH_W-1:0]    phase_q, phase_d;
  logic [T_W-1:0]     t_q, t_d;
  logic [TC_W-1:0]    ph_q, ph_d;
  logic [A_W-1:0]     hpos_q, hpos_d;
  logic [A_W-1:0]     base_q, base_d;
  logic [A_W-1:0]     ptr_q, ptr_d;
  logic [TC_W-1:0]    fill_q, fill_d;
  logic               out_v_q, out_v_d;
  out_beat_t          out_q, out_d;
  logic               s1_v_q, s1_v_d;
  logic               s1_ok_q, s1_ok_d;
  logic               s2_v_q;

  // Datapath.
  logic signed [15:0]      tap_mem [MAX_TAPS];
  logic signed [15:0]      hist_mem [MAX_TAPS];
  logic signed [15:0]      tap_rd_q, hist_rd_q;
  logic signed [31:0]      prod_q;
  logic signed [ACC_W-1:0] acc_q;
  logic                    acc_clr;
  logic signed [15:0]      res_q, res_d;

  // Combinational helpers.
  logic [U_W-1:0]  u_eff;
  logic [D_W-1:0]  d_eff;
  logic [TC_W-1:0] tc_eff;
  logic [D_W-1:0]  phase_inc;
  logic [PH_W-1:0] phase_adv;
  logic            bypass;
  logic            in_fire;
  logic            tap_we;
  logic            hist_we;
  logic            j_is_end;
  logic            res_byp;
  logic signed [RW-1:0] rnd_sum;
  logic signed [RW-1:0] rnd_shr;

  // Effective factors after clamping zero and out-of-range settings.
  always_comb begin
    if (up_q == '0) begin
      u_eff = U_W'(1);
    end else if (int'(up_q) > MAX_UP) begin
      u_eff = U_W'(MAX_UP);
    end else begin
      u_eff = U_W'(up_q);
    end
    if (down_q == '0) begin
      d_eff = D_W'(1);
    end else if (int'(down_q) > MAX_DOWN) begin
      d_eff = D_W'(MAX_DOWN);
    end else begin
      d_eff = D_W'(down_q);
    end
    if (int'(tc_q) > MAX_TAPS) begin
      tc_eff = TC_W'(MAX_TAPS);
    end else begin
      tc_eff = TC_W'(tc_q);
    end
  end

  assign bypass   = (u_eff == U_W'(1)) && (d_eff == D_W'(1)) && (tc_eff == '0);
  assign in_fire  = in_valid_i && in_ready_o;
  assign j_is_end = (U_W'(j_q) == (u_eff - U_W'(1)));

  // Decimation phase steps by one per upsampled value and wraps at D.
  assign phase_inc = D_W'(phase_q) + D_W'(1);
  assign phase_adv = (phase_inc >= d_eff) ? '0 : PH_W'(phase_inc);

  // Round half up at bit 14 and saturate to Q1.15.
  assign rnd_sum = RW'(acc_q) + RW'(RND_HALF);
  assign rnd_shr = rnd_sum >>> FRAC_SHIFT;
  always_comb begin
    if (rnd_shr > RW'(SAMPLE_MAX)) begin
      res_d = SAMPLE_MAX;
    end else if (rnd_shr < RW'(SAMPLE_MIN)) begin
      res_d = SAMPLE_MIN;
    end else begin
      res_d = rnd_shr[15:0];
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

  // Sequencer next-state logic.
  always_comb begin
    state_d    = state_q;
    up_d       = up_q;
    down_d     = down_q;
    tc_d       = tc_q;
    j_d        = j_q;
    last_j_d   = last_j_q;
    emit_vec_d = emit_vec_q;
    phase_d    = phase_q;
    t_d        = t_q;
    ph_d       = ph_q;
    hpos_d     = hpos_q;
    base_d     = base_q;
    ptr_d      = ptr_q;
    fill_d     = fill_q;
    out_v_d    = out_v_q && !out_ready_i;
    out_d      = out_q;
    s1_v_d     = 1'b0;
    s1_ok_d    = 1'b0;
    acc_clr    = 1'b0;
    tap_we     = 1'b0;
    hist_we    = 1'b0;

    // Register writes.
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_UP_FACTOR:   up_d   = cfg_data_i[UP_REG_W-1:0];
        REG_DOWN_FACTOR: down_d = cfg_data_i[DOWN_REG_W-1:0];
        REG_TAP_COUNT:   tc_d   = cfg_data_i[TC_REG_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_i.opcode == OP_COEF) begin
            tap_we = (int'(in_i.tap_index) < MAX_TAPS);
          end else begin
            hist_we = 1'b1;
            base_d  = ptr_q;
            ptr_d   = (ptr_q == A_W'(MAX_TAPS - 1)) ? '0 : ptr_q + A_W'(1);
            if (fill_q != TC_W'(MAX_TAPS)) begin
              fill_d = fill_q + TC_W'(1);
            end
            j_d = '0;
            if (bypass) begin
              phase_d  = '0;
              last_j_d = '0;
              state_d  = ST_EMIT;
            end else begin
              state_d = ST_SCAN;
            end
          end
        end
      end

      // Mark which phases emit and which one is the last of this sample.
      ST_SCAN: begin
        emit_vec_d[j_q] = (phase_q == '0);
        if (phase_q == '0) begin
          last_j_d = j_q;
        end
        phase_d = phase_adv;
        if (j_is_end) begin
          j_d     = '0;
          state_d = ST_NEXT;
        end else begin
          j_d = j_q + J_W'(1);
        end
      end

      // Start the tap walk for an emitting phase or skip to the next one.
      ST_NEXT: begin
        if (emit_vec_q[j_q]) begin
          t_d     = T_W'(j_q);
          ph_d    = '0;
          hpos_d  = base_q;
          acc_clr = 1'b1;
          state_d = ST_MAC;
        end else if (j_is_end) begin
          state_d = ST_IDLE;
        end else begin
          j_d = j_q + J_W'(1);
        end
      end

      // Issue one tap and one history read per cycle.
      ST_MAC: begin
        if (t_q < T_W'(tc_eff)) begin
          s1_v_d  = 1'b1;
          s1_ok_d = (ph_q < fill_q);
          t_d     = t_q + T_W'(u_eff);
          ph_d    = ph_q + TC_W'(1);
          hpos_d  = (hpos_q == '0) ? A_W'(MAX_TAPS - 1) : hpos_q - A_W'(1);
        end else begin
          state_d = ST_DRAIN;
        end
      end

      // Wait until the last product has reached the accumulator.
      ST_DRAIN: begin
        if (!s1_v_q && !s2_v_q) begin
          state_d = ST_EMIT;
        end
      end

      // Hand the result to the output register once it is free.
      ST_EMIT: begin
        if (!out_v_q || out_ready_i) begin
          out_v_d             = 1'b1;
          out_d.sample_out    = res_q;
          out_d.last_of_input = (j_q == last_j_q);
          if (j_q == last_j_q) begin
            state_d = ST_IDLE;
          end else begin
            j_d     = j_q + J_W'(1);
            state_d = ST_NEXT;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Bypass results go straight into the result register.
  assign res_byp = in_fire && (in_i.opcode == OP_SAMPLE) && bypass;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      up_q       <= UP_REG_W'(1);
      down_q     <= DOWN_REG_W'(1);
      tc_q       <= '0;
      j_q        <= '0;
      last_j_q   <= '0;
      emit_vec_q <= '0;
      phase_q    <= '0;
      t_q        <= '0;
      ph_q       <= '0;
      hpos_q     <= '0;
      base_q     <= '0;
      ptr_q      <= '0;
      fill_q     <= '0;
      out_v_q    <= 1'b0;
      s1_v_q     <= 1'b0;
      s1_ok_q    <= 1'b0;
      s2_v_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      up_q       <= up_d;
      down_q     <= down_d;
      tc_q       <= tc_d;
      j_q        <= j_d;
      last_j_q   <= last_j_d;
      emit_vec_q <= emit_vec_d;
      phase_q    <= phase_d;
      t_q        <= t_d;
      ph_q       <= ph_d;
      hpos_q     <= hpos_d;
      base_q     <= base_d;
      ptr_q      <= ptr_d;
      fill_q     <= fill_d;
      out_v_q    <= out_v_d;
      s1_v_q     <= s1_v_d;
      s1_ok_q    <= s1_ok_d;
      s2_v_q     <= s1_v_q;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // Tap store: written by coefficient beats, read every cycle at the current tap position.
  always_ff @(posedge clk_i) begin
    if (tap_we) begin
      tap_mem[A_W'(in_i.tap_index)] <= in_i.tap_value;
    end
    tap_rd_q <= tap_mem[t_q[A_W-1:0]];
  end

  // History line: the newest sample goes in at the write pointer.
  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[ptr_q] <= in_i.sample_in;
    end
    hist_rd_q <= hist_mem[hpos_q];
  end

  // Shared multiply-accumulate path; entries never filled count as zero.
  always_ff @(posedge clk_i) begin
    prod_q <= s1_ok_q ? (tap_rd_q * hist_rd_q) : 32'sd0;
    if (acc_clr) begin
      acc_q <= '0;
    end else if (s2_v_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    if (res_byp) begin
      res_q <= in_i.sample_in;
    end else if (state_q == ST_DRAIN) begin
      res_q <= res_d;
    end
  end

endmodule
